[rtl/gkbg_pkg.sv]
// ----------------------------------------------------------------------------
// gkbg_pkg
// Shared widths, tap lengths and configuration register indexes for the
// Geffe keystream byte generator.
// ----------------------------------------------------------------------------
package gkbg_pkg;

    localparam int SHORT_LEN  = 9;
    localparam int MIDDLE_LEN = 10;
    localparam int LONG_LEN   = 11;
    localparam int MAX_BITS   = 8;
    localparam int COUNT_W    = 4;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LONG_LEN;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_SHORT  = 2'd0,
        CFG_SEED_MIDDLE = 2'd1,
        CFG_SEED_LONG   = 2'd2
    } t_cfg_idx;

endpackage

[rtl/geffe_keystream_byte_generator.sv]
// ----------------------------------------------------------------------------
// geffe_keystream_byte_generator
// Three Fibonacci LFSRs (9, 10 and 11 bits) combined by a Geffe selector.
// Each input word asks for 0 to 8 keystream bits (larger counts clamp to 8),
// returned right-aligned with the earliest bit most significant.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  input    | i_valid / o_stall            | i_restart, i_bit_count
//  output   | o_valid / i_stall            | o_packed_byte
//  config   | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  One input word per cycle while o_stall is low; its result is registered.
//  The eight LFSR steps of a word are unrolled XOR logic in front of the
//  output register; the window registers feed back to the next word.
//  A skid register holds one result while the output is stalled; o_stall
//  goes high only while it is occupied.
//  Synchronous active-low reset sets seeds and windows to 1, empties outputs.
// ----------------------------------------------------------------------------
module geffe_keystream_byte_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_restart,
    input  logic [gkbg_pkg::COUNT_W-1:0]   i_bit_count,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [gkbg_pkg::BYTE_W-1:0]    o_packed_byte,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gkbg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gkbg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SL = gkbg_pkg::SHORT_LEN;
    localparam int ML = gkbg_pkg::MIDDLE_LEN;
    localparam int LL = gkbg_pkg::LONG_LEN;
    localparam int NB = gkbg_pkg::MAX_BITS;
    localparam int CW = gkbg_pkg::COUNT_W;
    localparam int BW = gkbg_pkg::BYTE_W;

    logic [SL-1:0] r_seed_short;
    logic [ML-1:0] r_seed_middle;
    logic [LL-1:0] r_seed_long;
    logic [SL-1:0] r_win_short,  n_win_short;
    logic [ML-1:0] r_win_middle, n_win_middle;
    logic [LL-1:0] r_win_long,   n_win_long;

    logic          r_out_valid;
    logic [BW-1:0] r_out_data;
    logic          r_skid_valid;
    logic [BW-1:0] r_skid_data;

    logic [SL+NB-1:0] ext_s;
    logic [ML+NB-1:0] ext_m;
    logic [LL+NB-1:0] ext_l;
    logic [NB-1:0]    key_rev;
    logic [CW-1:0]    count;
    logic [BW-1:0]    n_packed;
    logic             in_acc;

    assign o_cfg_ready   = 1'b1;
    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_packed_byte = r_out_data;
    assign in_acc        = i_valid & ~r_skid_valid;

    always_comb begin
        count = (i_bit_count > CW'(NB)) ? CW'(NB) : i_bit_count;
        ext_s = '0;
        ext_m = '0;
        ext_l = '0;
        ext_s[SL-1:0] = i_restart ? r_seed_short  : r_win_short;
        ext_m[ML-1:0] = i_restart ? r_seed_middle : r_win_middle;
        ext_l[LL-1:0] = i_restart ? r_seed_long   : r_win_long;
        for (int j = SL; j < SL + NB; j++) begin
            ext_s[j] = ext_s[j-9] ^ ext_s[j-8] ^ ext_s[j-6] ^ ext_s[j-5];
        end
        for (int j = ML; j < ML + NB; j++) begin
            ext_m[j] = ext_m[j-10] ^ ext_m[j-7];
        end
        for (int j = LL; j < LL + NB; j++) begin
            ext_l[j] = ext_l[j-11] ^ ext_l[j-9];
        end
        // earliest bit lands in the top position, then shift down to align
        for (int i = 0; i < NB; i++) begin
            key_rev[NB-1-i] = (ext_m[i] & ext_l[i]) ^ (~ext_m[i] & ext_s[i]);
        end
        n_packed     = BW'(key_rev >> (CW'(NB) - count));
        n_win_short  = ext_s[count +: SL];
        n_win_middle = ext_m[count +: ML];
        n_win_long   = ext_l[count +: LL];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_short  <= SL'(1);
            r_seed_middle <= ML'(1);
            r_seed_long   <= LL'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gkbg_pkg::CFG_SEED_SHORT:  r_seed_short  <= i_cfg_data[SL-1:0];
                gkbg_pkg::CFG_SEED_MIDDLE: r_seed_middle <= i_cfg_data[ML-1:0];
                gkbg_pkg::CFG_SEED_LONG:   r_seed_long   <= i_cfg_data[LL-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_short  <= SL'(1);
            r_win_middle <= ML'(1);
            r_win_long   <= LL'(1);
        end else if (in_acc) begin
            r_win_short  <= n_win_short;
            r_win_middle <= n_win_middle;
            r_win_long   <= n_win_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_acc) begin
                r_out_data <= n_packed;
            end
        end else if (in_acc) begin
            r_skid_data <= n_packed;
        end
    end

endmodule

[rtl/gkbg_checker.sv]
// ----------------------------------------------------------------------------
// gkbg_checker
// Port-level checks for the Geffe keystream byte generator, bound to the
// top level.
// ----------------------------------------------------------------------------
module gkbg_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_stall,
    input  logic                            i_restart,
    input  logic [gkbg_pkg::COUNT_W-1:0]    i_bit_count,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic [gkbg_pkg::BYTE_W-1:0]     o_packed_byte,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [gkbg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gkbg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not empty after reset");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall && i_valid))
        else $error("input stall raised without a stalled output");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid && i_bit_count == '0
        |=> o_valid && o_packed_byte == '0)
        else $error("zero bit count gave nonzero word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_packed_byte))
        else $error("stalled output word changed");

endmodule

bind geffe_keystream_byte_generator gkbg_checker u_gkbg_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Geffe keystream byte generator. Request words
// (reload flag, bit count) go in under random sender gaps and receiver
// stalls. A local three-LFSR model predicts each packed keystream byte, and
// every returned word is compared with it in order. The seed registers are
// rewritten between phases, extremes and the unused index included.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [gkbg_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                         restart;
        logic [gkbg_pkg::COUNT_W-1:0] count;
    } t_key_req;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic                            i_restart = 1'b0;
    logic [gkbg_pkg::COUNT_W-1:0]    i_bit_count = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [gkbg_pkg::BYTE_W-1:0]     o_packed_byte;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [gkbg_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [gkbg_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    t_key_req                    byte_requests[$];
    logic [gkbg_pkg::BYTE_W-1:0] key_bytes_due[$];
    t_key_req                    drv_word;
    logic [gkbg_pkg::BYTE_W-1:0] due_byte;

    logic [gkbg_pkg::SHORT_LEN-1:0]  seed_short = 1, short_win = 1;
    logic [gkbg_pkg::MIDDLE_LEN-1:0] seed_middle = 1, middle_win = 1;
    logic [gkbg_pkg::LONG_LEN-1:0]   seed_long = 1, long_win = 1;

    int  src_idle_pct = 19;
    int  sink_stall_pct = 65;
    logic hold_input = 1'b0;
    int  cycle_count = 0;
    int  fail_count = 0;
    int  words_sent = 0;
    int  reloads_sent = 0;
    int  bytes_checked = 0;
    int  seed_writes = 0;

    geffe_keystream_byte_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_restart     (i_restart),
        .i_bit_count   (i_bit_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_byte (o_packed_byte),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advances the three windows and packs the produced keystream bits.
    function automatic logic [gkbg_pkg::BYTE_W-1:0] next_key_byte(
            input logic restart, input logic [gkbg_pkg::COUNT_W-1:0] count);
        logic [gkbg_pkg::BYTE_W-1:0] acc;
        logic ks, fs, fm, fl;
        int n, k;
        acc = '0;
        if (restart) begin
            short_win  = seed_short;
            middle_win = seed_middle;
            long_win   = seed_long;
        end
        n = (int'(count) > gkbg_pkg::MAX_BITS) ? gkbg_pkg::MAX_BITS : int'(count);
        for (k = 0; k < n; k++) begin
            ks = middle_win[0] ? long_win[0] : short_win[0];
            fs = short_win[0] ^ short_win[1] ^ short_win[3] ^ short_win[4];
            fm = middle_win[0] ^ middle_win[3];
            fl = long_win[0] ^ long_win[2];
            short_win  = {fs, short_win[gkbg_pkg::SHORT_LEN-1:1]};
            middle_win = {fm, middle_win[gkbg_pkg::MIDDLE_LEN-1:1]};
            long_win   = {fl, long_win[gkbg_pkg::LONG_LEN-1:1]};
            acc = {acc[gkbg_pkg::BYTE_W-2:0], ks};
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                key_bytes_due = {key_bytes_due, next_key_byte(i_restart, i_bit_count)};
                words_sent++;
                if (i_restart) reloads_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (!hold_input && byte_requests.size() != 0 &&
                    $urandom_range(99) >= src_idle_pct) begin
                    drv_word = byte_requests.pop_front();
                    i_valid     <= 1'b1;
                    i_restart   <= drv_word.restart;
                    i_bit_count <= drv_word.count;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (key_bytes_due.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual %02h",
                         $time, o_packed_byte);
                fail_count++;
            end else begin
                due_byte = key_bytes_due.pop_front();
                bytes_checked++;
                if (o_packed_byte !== due_byte) begin
                    $display("%0t: packed_byte mismatch: expected %02h, actual %02h",
                             $time, due_byte, o_packed_byte);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_word(input logic restart,
                             input logic [gkbg_pkg::COUNT_W-1:0] count);
        t_key_req w;
        w.restart = restart;
        w.count   = count;
        byte_requests = {byte_requests, w};
    endtask

    task automatic queue_random_words(input int n);
        t_key_req w;
        repeat (n) begin
            w.restart = ($urandom_range(99) < 15);
            if ($urandom_range(99) < 88)
                w.count = gkbg_pkg::COUNT_W'($urandom_range(gkbg_pkg::MAX_BITS, 1));
            else
                w.count = gkbg_pkg::COUNT_W'(
                    $urandom_range((1 << gkbg_pkg::COUNT_W) - 1, 0));
            byte_requests = {byte_requests, w};
        end
    endtask

    task automatic drain_words;
        while (byte_requests.size() != 0 || i_valid || key_bytes_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [gkbg_pkg::CFG_IDX_W-1:0] idx,
                              input logic [gkbg_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            gkbg_pkg::CFG_SEED_SHORT:  seed_short  = data[gkbg_pkg::SHORT_LEN-1:0];
            gkbg_pkg::CFG_SEED_MIDDLE: seed_middle = data[gkbg_pkg::MIDDLE_LEN-1:0];
            gkbg_pkg::CFG_SEED_LONG:   seed_long   = data[gkbg_pkg::LONG_LEN-1:0];
            default: ;
        endcase
        seed_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_seeds(input logic [gkbg_pkg::CFG_DATA_W-1:0] s,
                               input logic [gkbg_pkg::CFG_DATA_W-1:0] m,
                               input logic [gkbg_pkg::CFG_DATA_W-1:0] l);
        write_seed(gkbg_pkg::CFG_SEED_SHORT, s);
        write_seed(gkbg_pkg::CFG_SEED_MIDDLE, m);
        write_seed(gkbg_pkg::CFG_SEED_LONG, l);
    endtask

    // Random seeds, leaning toward all-zero and all-one values
    task automatic shuffle_seeds;
        logic [gkbg_pkg::CFG_DATA_W-1:0] v;
        int idx;
        for (idx = 0; idx < 4; idx++) begin
            case ($urandom_range(3))
                0: v = '0;
                1: v = '1;
                default: v = gkbg_pkg::CFG_DATA_W'($urandom);
            endcase
            if (idx < 3 || $urandom_range(1) == 1)
                write_seed(gkbg_pkg::CFG_IDX_W'(idx), v);
        end
    endtask

    initial begin
        int ph, ch;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset seeds, zero count, oversized counts
        push_word(0, 8);  push_word(0, 1);  push_word(0, 0);  push_word(0, 15);
        push_word(0, 9);  push_word(0, 3);  push_word(1, 8);  push_word(1, 0);
        push_word(0, 8);  push_word(0, 7);  push_word(0, 12);
        drain_words();
        write_seeds('1, '1, '1);
        write_seed(CFG_IDX_UNUSED, '1);
        push_word(1, 8);  push_word(0, 8);  push_word(0, 2);  push_word(1, 6);
        push_word(0, 5);  push_word(0, 4);  push_word(0, 14);
        drain_words();
        // all-zero seeds lock the registers at zero
        write_seeds('0, '0, '0);
        write_seed(CFG_IDX_UNUSED, '0);
        push_word(1, 8);  push_word(0, 8);  push_word(0, 1);
        drain_words();
        write_seeds('0, '1, '1);
        push_word(1, 8);  push_word(0, 8);
        drain_words();
        write_seeds('1, '0, '0);
        push_word(1, 8);  push_word(0, 8);
        drain_words();

        for (ph = 0; ph < 3; ph++) begin
            src_idle_pct   <= (ph == 0) ? 19 : (ph == 1) ? 65 : 0;
            sink_stall_pct <= (ph == 0) ? 65 : (ph == 1) ? 19 : 0;
            for (ch = 0; ch < 3; ch++) begin
                shuffle_seeds();
                queue_random_words(100);
                if (ph == 0 && ch == 1) begin
                    while (byte_requests.size() > 50) @(posedge i_clk);
                    hold_input <= 1'b1;
                    @(posedge i_clk);
                    while (key_bytes_due.size() != 0 || i_valid) @(negedge i_clk);
                    hold_input <= 1'b0;
                end
                drain_words();
            end
        end

        repeat (10) @(posedge i_clk);
        $display("Checked %0d keystream words from %0d requests (%0d with reload),",
                 bytes_checked, words_sent, reloads_sent);
        $display("across %0d seed register writes and three handshake pressure phases.",
                 seed_writes);
        if (fail_count == 0 && key_bytes_due.size() == 0) begin
            $display("geffe_keystream_byte_generator test passed");
        end else begin
            $display("geffe_keystream_byte_generator test failed");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout with %0d words outstanding", $time, key_bytes_due.size());
        $display("geffe_keystream_byte_generator test failed");
        $finish;
    end

endmodule
